### hw/rtl/nnc_pkg.sv
// shared types and constants for the nearest neighbor classifier
// no dependencies; compiled first
`timescale 1ns / 1ps

package nnc_pkg;

	localparam int FEAT_W    = 16;
	localparam int LABEL_W   = 8;
	localparam int SLOT_W    = 4;
	localparam int SQ_W      = 2 * FEAT_W;
	localparam int DIST_W    = SQ_W + 1;

	// command kinds carried in the kind field
	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_QUERY = 1'b1
	} kind_t;

	// one entry as read back from the sample table
	typedef struct packed {
		logic               valid;
		logic [FEAT_W-1:0]  first;
		logic [FEAT_W-1:0]  second;
		logic [LABEL_W-1:0] label;
	} entry_rd_t;

	// write request into the sample table
	typedef struct packed {
		logic               en;
		logic [FEAT_W-1:0]  first;
		logic [FEAT_W-1:0]  second;
		logic [LABEL_W-1:0] label;
	} entry_wr_t;

endpackage

### hw/rtl/nnc_ifs.sv
// valid/ready channel interfaces for command and result beats
// depends on nnc_pkg
`timescale 1ns / 1ps

interface nnc_cmd_if import nnc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               kind;
	logic [SLOT_W-1:0]  entry_index;
	logic [FEAT_W-1:0]  first_feature;
	logic [FEAT_W-1:0]  second_feature;
	logic [LABEL_W-1:0] class_label;

	modport source (
		output valid, kind, entry_index, first_feature, second_feature, class_label,
		input  ready
	);
	modport sink (
		input  valid, kind, entry_index, first_feature, second_feature, class_label,
		output ready
	);
endinterface

interface nnc_res_if import nnc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               found;
	logic [LABEL_W-1:0] nearest_label;
	logic [SLOT_W-1:0]  nearest_index;
	logic [DIST_W-1:0]  squared_distance;

	modport source (
		output valid, found, nearest_label, nearest_index, squared_distance,
		input  ready
	);
	modport sink (
		input  valid, found, nearest_label, nearest_index, squared_distance,
		output ready
	);
endinterface

### hw/rtl/nnc_table.sv
// sample table: feature and label memory with one write and one registered read port,
// plus per-slot valid flops cleared by reset; depends on nnc_pkg
`timescale 1ns / 1ps

module nnc_table import nnc_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  entry_wr_t        wr,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_rd_t        rd
);

	logic [FEAT_W-1:0]  first_mem  [DEPTH];
	logic [FEAT_W-1:0]  second_mem [DEPTH];
	logic [LABEL_W-1:0] label_mem  [DEPTH];
	logic [DEPTH-1:0]   valid_q;

	logic [FEAT_W-1:0]  first_q;
	logic [FEAT_W-1:0]  second_q;
	logic [LABEL_W-1:0] label_q;
	logic               rd_valid_q;

	// payload memory, no reset
	always_ff @(posedge clk) begin
		if (wr.en) begin
			first_mem[wr_addr]  <= wr.first;
			second_mem[wr_addr] <= wr.second;
			label_mem[wr_addr]  <= wr.label;
		end
		if (rd_en) begin
			first_q  <= first_mem[rd_addr];
			second_q <= second_mem[rd_addr];
			label_q  <= label_mem[rd_addr];
		end
	end

	// valid marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd.valid  = rd_valid_q;
	assign rd.first  = first_q;
	assign rd.second = second_q;
	assign rd.label  = label_q;

endmodule

### hw/rtl/nnc_dist.sv
// shared squared distance unit: abs diff, square, sum over three stages
// carries an opaque tag alongside; depends on nnc_pkg
`timescale 1ns / 1ps

module nnc_dist import nnc_pkg::*; #(
	parameter int TAG_W = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_live,
	input  logic [TAG_W-1:0]  in_tag,
	input  logic [FEAT_W-1:0] qa,
	input  logic [FEAT_W-1:0] qb,
	input  logic [FEAT_W-1:0] sa,
	input  logic [FEAT_W-1:0] sb,
	output logic              out_live,
	output logic [TAG_W-1:0]  out_tag,
	output logic [DIST_W-1:0] out_dist
);

	logic              live_s1, live_s2, live_s3;
	logic [TAG_W-1:0]  tag_s1, tag_s2, tag_s3;
	logic [FEAT_W-1:0] dx_s1, dy_s1;
	logic [SQ_W-1:0]   sqx_s2, sqy_s2;
	logic [DIST_W-1:0] sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_s1 <= 1'b0;
			live_s2 <= 1'b0;
			live_s3 <= 1'b0;
		end else begin
			live_s1 <= in_live;
			live_s2 <= live_s1;
			live_s3 <= live_s2;
		end
	end

	always_ff @(posedge clk) begin
		// stage 1: absolute differences
		tag_s1 <= in_tag;
		dx_s1  <= (qa >= sa) ? (qa - sa) : (sa - qa);
		dy_s1  <= (qb >= sb) ? (qb - sb) : (sb - qb);
		// stage 2: squares
		tag_s2 <= tag_s1;
		sqx_s2 <= SQ_W'(dx_s1) * SQ_W'(dx_s1);
		sqy_s2 <= SQ_W'(dy_s1) * SQ_W'(dy_s1);
		// stage 3: sum
		tag_s3 <= tag_s2;
		sum_s3 <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
	end

	assign out_live = live_s3;
	assign out_tag  = tag_s3;
	assign out_dist = sum_s3;

endmodule

### hw/rtl/nearest_neighbor_classifier.sv
// one-nearest-neighbor classifier, top level: command decode, scan sequencer,
// best-match tracking and result register; depends on nnc_pkg, nnc_ifs, nnc_table, nnc_dist
`timescale 1ns / 1ps

// Usage
//   cmd: valid/ready sink. kind = load writes first_feature, second_feature and
//   class_label into slot entry_index and marks it valid (slots at or above
//   TABLE_DEPTH are dropped); kind = query classifies the point given by the features.
//   res: valid/ready source, one beat per query, none per load.
//   A load beat leaves cmd.ready high.
//   A query walks all TABLE_DEPTH slots through one shared distance unit, one slot
//   per cycle, in the scan state; the drain state then empties the table read and the
//   three-stage distance pipe, and the emit state loads the result register. The block
//   takes no further command until the emit state has loaded the result register, so
//   one query finishes before the next command is taken.
//   The result sits in an output register: while it waits, further load or query
//   beats are taken; a query that finishes while the previous result is still
//   unclaimed holds in its final state, with cmd.ready low, until res.ready.
//   Ties keep the lowest slot; an empty table answers found = 0 with zero fields.
//   Reset clears all valid marks, the sequencer and the result valid flag; the sample
//   memory itself keeps no reset value and needs no clearing pass.
module nearest_neighbor_classifier import nnc_pkg::*; #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	nnc_cmd_if.sink   cmd,
	nnc_res_if.source res
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int TAG_W = IDX_W + LABEL_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
	// table read plus distance stages
	localparam logic [1:0] DRAIN_LAST = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	logic [IDX_W-1:0]  scan_q;
	logic [1:0]        drain_q;
	logic [FEAT_W-1:0] qa_q, qb_q;

	logic              issue_s1;
	logic [IDX_W-1:0]  idx_s1;

	logic              have_q;
	logic [DIST_W-1:0] best_dist_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [LABEL_W-1:0] best_lab_q;

	logic               res_valid_q;
	logic               res_found_q;
	logic [LABEL_W-1:0] res_lab_q;
	logic [SLOT_W-1:0]  res_idx_q;
	logic [DIST_W-1:0]  res_dist_q;

	logic cmd_fire, load_fire, query_fire, slot_ok, emit_go, take_res, upd;

	entry_wr_t        tbl_wr;
	logic [IDX_W-1:0] tbl_wr_addr;
	logic             rd_en;
	entry_rd_t        tbl_rd;

	logic              dv_live;
	logic [TAG_W-1:0]  dv_tag;
	logic [DIST_W-1:0] dv_dist;
	logic [IDX_W-1:0]  dv_idx;
	logic [LABEL_W-1:0] dv_lab;

	// command decode
	assign cmd.ready  = (state_q == ST_IDLE);
	assign cmd_fire   = cmd.valid && cmd.ready;
	assign query_fire = cmd_fire && (cmd.kind == KIND_QUERY);
	assign load_fire  = cmd_fire && (cmd.kind == KIND_LOAD);
	// out-of-range slots are dropped silently
	assign slot_ok    = (32'(cmd.entry_index) < TABLE_DEPTH);

	assign tbl_wr.en     = load_fire && slot_ok;
	assign tbl_wr.first  = cmd.first_feature;
	assign tbl_wr.second = cmd.second_feature;
	assign tbl_wr.label  = cmd.class_label;
	assign tbl_wr_addr   = IDX_W'(cmd.entry_index);

	assign rd_en = (state_q == ST_SCAN);

	nnc_table #(
		.DEPTH (TABLE_DEPTH),
		.IDX_W (IDX_W)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (tbl_wr),
		.wr_addr (tbl_wr_addr),
		.rd_en   (rd_en),
		.rd_addr (scan_q),
		.rd      (tbl_rd)
	);

	// only slots that were issued in this scan and hold a sample enter the unit
	nnc_dist #(
		.TAG_W (TAG_W)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_live  (issue_s1 && tbl_rd.valid),
		.in_tag   ({idx_s1, tbl_rd.label}),
		.qa       (qa_q),
		.qb       (qb_q),
		.sa       (tbl_rd.first),
		.sb       (tbl_rd.second),
		.out_live (dv_live),
		.out_tag  (dv_tag),
		.out_dist (dv_dist)
	);

	assign dv_idx = dv_tag[TAG_W-1:LABEL_W];
	assign dv_lab = dv_tag[LABEL_W-1:0];

	// strict compare so an equal distance keeps the earlier slot
	assign upd = dv_live && (!have_q || (dv_dist < best_dist_q));

	assign take_res = res_valid_q && res.ready;
	assign emit_go  = (state_q == ST_EMIT) && (!res_valid_q || res.ready);

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (query_fire) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_q == DRAIN_LAST) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_go) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_q      <= '0;
			drain_q     <= '0;
			issue_s1    <= 1'b0;
			have_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			issue_s1 <= rd_en;

			if (query_fire) begin
				scan_q <= '0;
			end else if (rd_en && (scan_q != LAST_IDX)) begin
				scan_q <= scan_q + 1'b1;
			end

			if (state_q == ST_DRAIN) begin
				drain_q <= drain_q + 2'd1;
			end else begin
				drain_q <= '0;
			end

			if (query_fire) begin
				have_q <= 1'b0;
			end else if (upd) begin
				have_q <= 1'b1;
			end

			if (emit_go) begin
				res_valid_q <= 1'b1;
			end else if (take_res) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= scan_q;
		if (query_fire) begin
			qa_q        <= cmd.first_feature;
			qb_q        <= cmd.second_feature;
			best_dist_q <= '0;
			best_idx_q  <= '0;
			best_lab_q  <= '0;
		end else if (upd) begin
			best_dist_q <= dv_dist;
			best_idx_q  <= dv_idx;
			best_lab_q  <= dv_lab;
		end
		if (emit_go) begin
			res_found_q <= have_q;
			res_lab_q   <= have_q ? best_lab_q : '0;
			res_idx_q   <= have_q ? SLOT_W'(best_idx_q) : '0;
			res_dist_q  <= have_q ? best_dist_q : '0;
		end
	end

	assign res.valid            = res_valid_q;
	assign res.found            = res_found_q;
	assign res.nearest_label    = res_lab_q;
	assign res.nearest_index    = res_idx_q;
	assign res.squared_distance = res_dist_q;

	// a result beat only appears out of the final sequencer state
	a_res_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("result raised outside emit");

	// nothing in flight while commands are taken
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!issue_s1 && !dv_live))
		else $error("scan pipe busy while idle");

	// an empty answer carries zero fields
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_found_q) |->
		(res_dist_q == '0 && res_idx_q == '0 && res_lab_q == '0))
		else $error("empty answer with nonzero fields");

	// replacements follow scan order and only with a smaller distance
	a_best_moves_up: assert property (@(posedge clk) disable iff (!arst_n)
		(have_q && upd && !query_fire) |=>
		(best_idx_q > $past(best_idx_q) && best_dist_q < $past(best_dist_q)))
		else $error("best match moved backward");

endmodule
